FILE: src/dna_context_count_model_defines.svh
// Assertion macros shared by the DNA context count model RTL.
`ifndef DNA_CONTEXT_COUNT_MODEL_DEFINES_SVH
`define DNA_CONTEXT_COUNT_MODEL_DEFINES_SVH
`ifndef SYNTHESIS
`define DCM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dcm assertion failed");
`define DCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcm assertion failed");
`else
`define DCM_ASSERT(label, clk, rst, prop)
`define DCM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/dcm_pkg.sv
// Package with types and constants of the DNA context count model.
`timescale 1ns / 1ps
package dcm_pkg;

   // Default sizes of the count table.
   localparam int MAX_CTX_DEF    = 8;
   localparam int COUNT_BITS_DEF = 8;

   // Field widths.
   localparam int OP_W      = 2;
   localparam int SYM_W     = 2;
   localparam int ORDER_W   = 4;
   localparam int ALPHA_W   = 10;
   localparam int LIMIT_W   = 8;
   localparam int FREQ_W    = 18;
   localparam int TOTAL_W   = 20;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 10;

   // Largest reportable frequency; larger values saturate.
   localparam int FREQ_MAX = (1 << FREQ_W) - 1;

   // Register reset values.
   localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(8);
   localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(16);
   localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(255);

   // Command codes.
   typedef enum logic [OP_W-1:0] {
      OP_COMPUTE   = 2'd0,
      OP_UPDATE    = 2'd1,
      OP_SHIFT_FWD = 2'd2,
      OP_SHIFT_REV = 2'd3
   } op_type;

   // Register indexes on the control port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORDER = 2'd0,
      CSR_ALPHA = 2'd1,
      CSR_LIMIT = 2'd2,
      CSR_NONE  = 2'd3
   } csr_idx_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_SCALE,
      ST_SUM
   } state_type;

endpackage

FILE: src/dna_context_count_model.sv
// Order-k DNA context count model: count table memory, index registers and frequency output.
// A compute transfer holds busy through the scale and sum states; the result strobe is registered from the sum state.
// An update holds busy in the update state while the table word read at acceptance is modified and written back.
// Shift commands complete at acceptance. Throughput: 1 item per cycle for shifts; an update or
// compute holds busy until its states are done, so no new command is taken meanwhile.
// Reset clears all 4^MAX_CTX table words (65536 by default) in one pass with busy high.
`timescale 1ns / 1ps
`include "dna_context_count_model_defines.svh"
module dna_context_count_model
   import dcm_pkg::*;
#(
   parameter int MAX_CTX    = MAX_CTX_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_op,
   input  logic [SYM_W-1:0]     req_sym,
   input  logic                 req_use_reverse,
   output logic                 rsp_valid,
   output logic [FREQ_W-1:0]    rsp_freq_a,
   output logic [FREQ_W-1:0]    rsp_freq_c,
   output logic [FREQ_W-1:0]    rsp_freq_g,
   output logic [FREQ_W-1:0]    rsp_freq_t,
   output logic [TOTAL_W-1:0]   rsp_freq_total,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W   = 2 * MAX_CTX;
   localparam int NUM_CTX = 1 << IDX_W;
   localparam int WORD_W  = 4 * COUNT_BITS;
   localparam int KW      = $clog2(MAX_CTX + 1);
   localparam int PROD_W  = ALPHA_W + COUNT_BITS;
   localparam int INC_W   = COUNT_BITS + 1;
   localparam int CMP_W   = (INC_W > LIMIT_W) ? INC_W : LIMIT_W;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] fwd_idx_ff, fwd_idx_in;
   logic [IDX_W-1:0] rev_idx_ff, rev_idx_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic [ORDER_W-1:0] cfg_order_ff, cfg_order_in;
   logic [ALPHA_W-1:0] cfg_alpha_ff, cfg_alpha_in;
   logic [LIMIT_W-1:0] cfg_limit_ff, cfg_limit_in;
   logic [FREQ_W-1:0] freq_ff [4];
   logic [FREQ_W-1:0] freq_in [4];
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic valid_ff, valid_in;

   logic [WORD_W-1:0] table_mem [NUM_CTX];
   logic [WORD_W-1:0] rd_data_ff;

   logic accept;
   logic [KW-1:0] ord_k;
   logic [IDX_W-1:0] ctx_mask;
   logic [IDX_W-1:0] fwd_shift, rev_shift;
   logic [IDX_W-1:0] rd_addr;
   logic [WORD_W-1:0] upd_word;
   logic mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   assign accept = start && !busy;

   // Effective order clamped to 1..MAX_CTX and the matching index mask.
   always_comb begin
      if (cfg_order_ff == '0) begin
         ord_k = KW'(1);
      end else if (int'(cfg_order_ff) > MAX_CTX) begin
         ord_k = KW'(MAX_CTX);
      end else begin
         ord_k = KW'(cfg_order_ff);
      end
      for (int b = 0; b < IDX_W; b++) begin
         ctx_mask[b] = (b < 2 * int'(ord_k));
      end
   end

   // Shifted indexes: the forward one takes the symbol at the bottom, the reverse one
   // takes the complement at the top of the active context.
   always_comb begin
      fwd_shift = (((fwd_idx_ff & ctx_mask) << 2) | IDX_W'(req_sym)) & ctx_mask;
      rev_shift = (rev_idx_ff & ctx_mask) >> 2;
      for (int j = 0; j < MAX_CTX; j++) begin
         if (j == int'(ord_k) - 1) begin
            rev_shift[2*j +: 2] = ~req_sym;
         end
      end
   end

   // Table address of the accepted command.
   always_comb begin
      if (op_type'(req_op) == OP_UPDATE && req_use_reverse) begin
         rd_addr = rev_idx_ff & ctx_mask;
      end else begin
         rd_addr = fwd_idx_ff & ctx_mask;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_op))
                  OP_COMPUTE: state_in = ST_SCALE;
                  OP_UPDATE:  state_in = ST_UPDATE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         ST_SCALE:  state_in = ST_SUM;
         ST_SUM:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Controller outputs: busy flag and table write port.
   always_comb begin
      busy      = 1'b1;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = upd_word;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_UPDATE: begin
            mem_we = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Read-modify-write of one context word. When the old count is saturated or the incremented count
   // reaches the limit, all four counts of the context are halved.
   always_comb begin
      logic [COUNT_BITS-1:0] old_cnt;
      logic [INC_W-1:0] inc_cnt;
      logic [INC_W-1:0] cur;
      logic halve;
      old_cnt  = rd_data_ff[int'(sym_ff)*COUNT_BITS +: COUNT_BITS];
      inc_cnt  = INC_W'(old_cnt) + INC_W'(1);
      halve    = (old_cnt == '1) || (CMP_W'(inc_cnt) >= CMP_W'(cfg_limit_ff));
      upd_word = rd_data_ff;
      for (int j = 0; j < 4; j++) begin
         if (j == int'(sym_ff)) begin
            cur = inc_cnt;
         end else begin
            cur = INC_W'(rd_data_ff[j*COUNT_BITS +: COUNT_BITS]);
         end
         if (halve) begin
            upd_word[j*COUNT_BITS +: COUNT_BITS] = cur[COUNT_BITS:1];
         end else begin
            upd_word[j*COUNT_BITS +: COUNT_BITS] = cur[COUNT_BITS-1:0];
         end
      end
   end

   // Frequencies 1 + alpha * count, saturated to the output width.
   always_comb begin
      logic [PROD_W:0] f;
      for (int j = 0; j < 4; j++) begin
         f = (PROD_W + 1)'(PROD_W'(cfg_alpha_ff)
              * PROD_W'(rd_data_ff[j*COUNT_BITS +: COUNT_BITS])) + (PROD_W + 1)'(1);
         if (state_ff == ST_SCALE) begin
            if (32'(f) > 32'(FREQ_MAX)) begin
               freq_in[j] = FREQ_W'(FREQ_MAX);
            end else begin
               freq_in[j] = FREQ_W'(f);
            end
         end else begin
            freq_in[j] = freq_ff[j];
         end
      end
   end

   // Total and result strobe.
   always_comb begin
      valid_in = (state_ff == ST_SUM);
      if (state_ff == ST_SUM) begin
         total_in = TOTAL_W'(freq_ff[0]) + TOTAL_W'(freq_ff[1])
                  + TOTAL_W'(freq_ff[2]) + TOTAL_W'(freq_ff[3]);
      end else begin
         total_in = total_ff;
      end
   end

   // Index registers, command capture and clearing counter.
   always_comb begin
      fwd_idx_in = fwd_idx_ff;
      rev_idx_in = rev_idx_ff;
      addr_in    = addr_ff;
      sym_in     = sym_ff;
      clr_in     = clr_ff;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + IDX_W'(1);
      end
      if (accept) begin
         addr_in = rd_addr;
         sym_in  = req_sym;
         case (op_type'(req_op))
            OP_SHIFT_FWD: fwd_idx_in = fwd_shift;
            OP_SHIFT_REV: rev_idx_in = rev_shift;
            default: begin
               fwd_idx_in = fwd_idx_ff;
            end
         endcase
      end
   end

   // Configuration writes; an unused index is ignored.
   always_comb begin
      cfg_order_in = cfg_order_ff;
      cfg_alpha_in = cfg_alpha_ff;
      cfg_limit_in = cfg_limit_ff;
      if (csr_write_enable) begin
         case (csr_idx_type'(csr_index))
            CSR_ORDER: cfg_order_in = csr_wdata[ORDER_W-1:0];
            CSR_ALPHA: cfg_alpha_in = csr_wdata[ALPHA_W-1:0];
            CSR_LIMIT: cfg_limit_in = csr_wdata[LIMIT_W-1:0];
            default:   cfg_order_in = cfg_order_ff;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         fwd_idx_ff   <= '0;
         rev_idx_ff   <= '0;
         cfg_order_ff <= ORDER_RST;
         cfg_alpha_ff <= ALPHA_RST;
         cfg_limit_ff <= LIMIT_RST;
         valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fwd_idx_ff   <= fwd_idx_in;
         rev_idx_ff   <= rev_idx_in;
         cfg_order_ff <= cfg_order_in;
         cfg_alpha_ff <= cfg_alpha_in;
         cfg_limit_ff <= cfg_limit_in;
         valid_ff     <= valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      sym_ff   <= sym_in;
      total_ff <= total_in;
      for (int j = 0; j < 4; j++) begin
         freq_ff[j] <= freq_in[j];
      end
   end

   // Count table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_freq_a     = freq_ff[0];
   assign rsp_freq_c     = freq_ff[1];
   assign rsp_freq_g     = freq_ff[2];
   assign rsp_freq_t     = freq_ff[3];
   assign rsp_freq_total = total_ff;

   // A compute transfer is always followed by its result strobe.
   `DCM_ASSERT(a_compute_result, clock, reset, (start && !busy && req_op == OP_COMPUTE) |-> ##3 rsp_valid)
   // Scaling is always followed by the summing step.
   `DCM_ASSERT_NEXT(a_scale_then_sum, clock, reset, state_ff == ST_SCALE, state_ff == ST_SUM)
   // No result leaves during the clearing pass.
   `DCM_ASSERT(a_clear_quiet, clock, reset, (state_ff == ST_CLEAR) |-> !valid_ff)

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the order-k DNA context count model.
`timescale 1ns / 1ps
module testbench
   import dcm_pkg::*;
();

   localparam int COUNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
   localparam int NUM_CTX     = 1 << (2 * MAX_CTX_DEF);
   localparam int CYCLE_LIMIT = 400000;

   // One command for the block.
   typedef struct {
      op_type     op;
      logic [1:0] sym;
      logic       use_rev;
   } dna_cmd_type;

   // One set of frequencies reported by a compute.
   typedef struct {
      logic [FREQ_W-1:0]  freq_a;
      logic [FREQ_W-1:0]  freq_c;
      logic [FREQ_W-1:0]  freq_g;
      logic [FREQ_W-1:0]  freq_t;
      logic [TOTAL_W-1:0] freq_total;
   } freq_set_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [OP_W-1:0]      req_op = OP_COMPUTE;
   logic [SYM_W-1:0]     req_sym = '0;
   logic                 req_use_reverse = 1'b0;
   logic                 rsp_valid;
   logic [FREQ_W-1:0]    rsp_freq_a;
   logic [FREQ_W-1:0]    rsp_freq_c;
   logic [FREQ_W-1:0]    rsp_freq_g;
   logic [FREQ_W-1:0]    rsp_freq_t;
   logic [TOTAL_W-1:0]   rsp_freq_total;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ORDER;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Shadow copy of the block's registers and state.
   logic [ORDER_W-1:0] cfg_order = ORDER_RST;
   logic [ALPHA_W-1:0] cfg_alpha = ALPHA_RST;
   logic [LIMIT_W-1:0] cfg_limit = LIMIT_RST;
   bit [15:0]          sym_counts [0:NUM_CTX-1][0:3];
   int                 fwd_index = 0;
   int                 rev_index = 0;

   dna_cmd_type  pending_cmds [$];
   freq_set_type expected_freqs [$];
   dna_cmd_type  cur_cmd;
   int           burst_left = 4;
   int           gap_left = 0;
   int           error_count = 0;
   int           cycle_count = 0;

   dna_context_count_model i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_sym         (req_sym),
      .req_use_reverse (req_use_reverse),
      .rsp_valid       (rsp_valid),
      .rsp_freq_a      (rsp_freq_a),
      .rsp_freq_c      (rsp_freq_c),
      .rsp_freq_g      (rsp_freq_g),
      .rsp_freq_t      (rsp_freq_t),
      .rsp_freq_total  (rsp_freq_total),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one accepted command to the shadow state and record any frequencies it reports.
   function automatic void apply_dna_cmd(input dna_cmd_type c);
      int           k;
      int           mask;
      int           ctx;
      int           old_cnt;
      int           new_cnt;
      int           val;
      int           total;
      int           fv [4];
      freq_set_type fs;
      k = (cfg_order < 1) ? 1 : ((cfg_order > MAX_CTX_DEF) ? MAX_CTX_DEF : int'(cfg_order));
      mask = (1 << (2 * k)) - 1;
      case (c.op)
         OP_COMPUTE: begin
            ctx = fwd_index & mask;
            total = 0;
            for (int j = 0; j < 4; j++) begin
               fv[j] = 1 + int'(cfg_alpha) * int'(sym_counts[ctx][j]);
               if (fv[j] > FREQ_MAX) fv[j] = FREQ_MAX;
               total += fv[j];
            end
            fs.freq_a = FREQ_W'(fv[0]);
            fs.freq_c = FREQ_W'(fv[1]);
            fs.freq_g = FREQ_W'(fv[2]);
            fs.freq_t = FREQ_W'(fv[3]);
            fs.freq_total = total[TOTAL_W-1:0];
            expected_freqs.push_back(fs);
         end
         OP_UPDATE: begin
            ctx = (c.use_rev ? rev_index : fwd_index) & mask;
            old_cnt = int'(sym_counts[ctx][c.sym]);
            new_cnt = old_cnt + 1;
            // A saturated count or reaching the limit halves all four counts of the context.
            if (old_cnt >= COUNT_MAX || new_cnt >= int'(cfg_limit)) begin
               for (int j = 0; j < 4; j++) begin
                  val = (j == c.sym) ? new_cnt : int'(sym_counts[ctx][j]);
                  sym_counts[ctx][j] = 16'(val >> 1);
               end
            end else begin
               sym_counts[ctx][c.sym] = 16'(new_cnt);
            end
         end
         OP_SHIFT_FWD: begin
            fwd_index = (((fwd_index & mask) << 2) + c.sym) & mask;
         end
         default: begin
            rev_index = (((rev_index & mask) >> 2) + ((3 - c.sym) << (2 * (k - 1)))) & mask;
         end
      endcase
   endfunction

   // Driver: presents queued commands in bursts and updates the shadow state on each transfer.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_dna_cmd(cur_cmd);
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 12);
               gap_left = $urandom_range(1, 6);
            end
         end
         if (start && busy) begin
            // Hold the command until it is taken.
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            cur_cmd = pending_cmds.pop_front();
            req_op <= cur_cmd.op;
            req_sym <= cur_cmd.sym;
            req_use_reverse <= cur_cmd.use_rev;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
         error_count++;
      end
   endtask

   // Monitor: compares each reported frequency set with the oldest expected one.
   always @(posedge clock) begin
      freq_set_type fs;
      if (!reset && rsp_valid) begin
         if (expected_freqs.size() == 0) begin
            $error("unexpected frequency result: freq_total %0d", rsp_freq_total);
            error_count++;
         end else begin
            fs = expected_freqs.pop_front();
            check_field("freq_a", int'(fs.freq_a), int'(rsp_freq_a));
            check_field("freq_c", int'(fs.freq_c), int'(rsp_freq_c));
            check_field("freq_g", int'(fs.freq_g), int'(rsp_freq_g));
            check_field("freq_t", int'(fs.freq_t), int'(rsp_freq_t));
            check_field("freq_total", int'(fs.freq_total), int'(rsp_freq_total));
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic push_cmd(input op_type op, input int sym, input bit use_rev);
      dna_cmd_type c;
      c.op = op;
      c.sym = sym[1:0];
      c.use_rev = use_rev;
      pending_cmds.push_back(c);
   endtask

   // Random command; in hammer mode most commands update one hot count.
   function automatic dna_cmd_type random_cmd(input bit hammer, input logic [1:0] hot_sym);
      dna_cmd_type c;
      int          r;
      r = $urandom_range(0, 99);
      c.sym = 2'($urandom_range(0, 3));
      c.use_rev = 1'($urandom_range(0, 1));
      if (hammer && r < 88) begin
         c.op = OP_UPDATE;
         c.sym = hot_sym;
         c.use_rev = (r < 80) ? 1'b0 : 1'b1;
      end else if (hammer && r < 97) begin
         c.op = OP_COMPUTE;
      end else if (r < 30) begin
         c.op = OP_COMPUTE;
      end else if (r < 60) begin
         c.op = OP_UPDATE;
      end else if (r < 82) begin
         c.op = OP_SHIFT_FWD;
      end else begin
         c.op = OP_SHIFT_REV;
      end
      return c;
   endfunction

   // Wait until every command is taken, every result is in and the block is idle.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || busy || expected_freqs.size() != 0);
   endtask

   task automatic write_csr(input csr_idx_type idx, input int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      case (idx)
         CSR_ORDER: cfg_order = value[ORDER_W-1:0];
         CSR_ALPHA: cfg_alpha = value[ALPHA_W-1:0];
         CSR_LIMIT: cfg_limit = value[LIMIT_W-1:0];
         default: begin
         end
      endcase
   endtask

   // Reconfigure the idle block, then run a batch of random commands.
   task automatic run_phase(input int order, input int alpha, input int limit, input int n,
                            input bit hammer);
      logic [1:0] hot_sym;
      wait_drained();
      repeat (8) @(posedge clock);
      write_csr(CSR_ORDER, order);
      write_csr(CSR_ALPHA, alpha);
      write_csr(CSR_LIMIT, limit);
      write_csr(CSR_NONE, $urandom_range(0, 1023));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      hot_sym = 2'($urandom_range(0, 3));
      for (int i = 0; i < n; i++) pending_cmds.push_back(random_cmd(hammer, hot_sym));
   endtask

   // Stimulus: reset, a directed pass at the reset settings, then random phases.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // The table is cleared after reset while busy is high.
      do @(negedge clock); while (busy);

      // Directed: zero counts, every command and symbol, both index kinds.
      push_cmd(OP_COMPUTE, 0, 1'b0);
      for (int s = 0; s < 4; s++) push_cmd(OP_UPDATE, s, 1'b0);
      push_cmd(OP_UPDATE, 3, 1'b1);
      push_cmd(OP_COMPUTE, 0, 1'b0);
      for (int s = 3; s >= 0; s--) push_cmd(OP_SHIFT_FWD, s, 1'b0);
      push_cmd(OP_SHIFT_REV, 0, 1'b1);
      push_cmd(OP_SHIFT_REV, 3, 1'b0);
      push_cmd(OP_SHIFT_REV, 1, 1'b1);
      push_cmd(OP_SHIFT_REV, 2, 1'b0);
      push_cmd(OP_UPDATE, 2, 1'b0);
      push_cmd(OP_UPDATE, 1, 1'b1);
      push_cmd(OP_COMPUTE, 3, 1'b1);
      push_cmd(OP_UPDATE, 2, 1'b0);
      push_cmd(OP_COMPUTE, 0, 1'b0);

      // Order 1 with the largest alpha drives one count up to the limit.
      run_phase(1, 1023, 255, 360, 1'b1);
      // Order below range, zero alpha, limit zero.
      run_phase(0, 0, 0, 90, 1'b0);
      // Order above range, limit one.
      run_phase(15, 512, 1, 90, 1'b0);
      run_phase(2, 1, 2, 90, 1'b0);
      run_phase(4, 300, 3, 90, 1'b0);
      run_phase(8, 1023, 255, 90, 1'b0);
      run_phase(3, $urandom_range(1, 1023), $urandom_range(2, 255), 90, 1'b0);
      run_phase(5, 16, 40, 100, 1'b1);

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_freqs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/dcm_pkg.sv
src/dna_context_count_model.sv
tb/sv/testbench.sv
